/* sv/bounded_deque_with_search_macros.svh */
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

// Plain property checked on every clock edge outside reset.
`define BDQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BDQS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BDQS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/bdqs_pkg.sv */
// Types and codes for the bounded deque with search.
`default_nettype none
package bdqs_pkg;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] entry_count;
  } rsp_t;

endpackage
`default_nettype wire

/* sv/bounded_deque_with_search.sv */
// Push/pop: the result is registered at accept and offered in the next cycle.
// A search reads one held entry per cycle through the RAM read port and compares it,
// stopping at the first match.
// One request is in flight at a time; the next is taken as the result beat leaves.
// Reset clears front pointer, count and control; the entry RAM is not cleared.
`default_nettype none
`include "bounded_deque_with_search_macros.svh"
module bounded_deque_with_search
  import bdqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rsp_t      out_rsp_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic          state_q, state_d;
  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [31:0]   key_q, key_d;
  logic          out_valid_q, out_valid_d;
  rsp_t          rsp_q, rsp_d;

  logic          accept;
  logic          full, empty;
  logic [CW:0]   slot_sum;
  logic [PW-1:0] back_slot;
  logic [PW-1:0] front_prev, front_next, rd_ptr_next;
  logic          we;
  logic [PW-1:0] waddr;
  logic          re;
  logic [31:0]   rdata;
  logic          hit;
  logic          searching;

  assign searching  = (state_q == ST_SEARCH);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == CW'(DEPTH));
  assign empty      = (cnt_q == '0);

  // (front + count) mod DEPTH; sum stays below 2*DEPTH
  assign slot_sum  = (CW+1)'(front_q) + (CW+1)'(cnt_q);
  assign back_slot = (slot_sum >= (CW+1)'(DEPTH)) ? PW'(slot_sum - (CW+1)'(DEPTH))
                                                   : PW'(slot_sum);

  assign front_prev  = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_next  = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);
  assign rd_ptr_next = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

  assign hit = cmp_vld_q && (rdata == key_q);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    rd_ptr_d    = rd_ptr_q;
    cmp_vld_d   = 1'b0;
    key_d       = key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;
    we          = 1'b0;
    waddr       = front_prev;
    re          = 1'b0;

    if (state_q == ST_IDLE) begin
      if (accept) begin
        rsp_d.status = STATUS_OK;
        rsp_d.found  = 1'b0;
        out_valid_d  = 1'b1;
        case (in_req_i.req_type)
          REQ_PUSH_FRONT: begin
            if (full) begin
              rsp_d.status = STATUS_FULL;
            end else begin
              we      = 1'b1;
              waddr   = front_prev;
              front_d = front_prev;
              cnt_d   = cnt_q + CW'(1);
            end
          end
          REQ_PUSH_BACK: begin
            if (full) begin
              rsp_d.status = STATUS_FULL;
            end else begin
              we    = 1'b1;
              waddr = back_slot;
              cnt_d = cnt_q + CW'(1);
            end
          end
          REQ_POP_FRONT: begin
            if (empty) begin
              rsp_d.status = STATUS_EMPTY;
            end else begin
              front_d = front_next;
              cnt_d   = cnt_q - CW'(1);
            end
          end
          REQ_POP_BACK: begin
            if (empty) begin
              rsp_d.status = STATUS_EMPTY;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end
          REQ_SEARCH: begin
            out_valid_d = 1'b0;
            state_d     = ST_SEARCH;
            idx_d       = '0;
            rd_ptr_d    = front_q;
            key_d       = in_req_i.value;
          end
          default: ;
        endcase
        rsp_d.entry_count = 5'(cnt_d);
      end
    end else begin
      // compare the previous read, else issue the next one
      if (hit || (idx_q == cnt_q)) begin
        state_d           = ST_IDLE;
        out_valid_d       = 1'b1;
        rsp_d.status      = STATUS_OK;
        rsp_d.found       = hit;
        rsp_d.entry_count = 5'(cnt_q);
      end else begin
        re        = 1'b1;
        cmp_vld_d = 1'b1;
        idx_d     = idx_q + CW'(1);
        rd_ptr_d  = rd_ptr_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_ptr_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_ptr_q    <= rd_ptr_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  bdqs_ram #(
    .Width(32),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(in_req_i.value),
    .re_i   (re),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  `BDQS_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "held count above DEPTH")
  `BDQS_ASSERT(a_front_bound, front_q <= PW'(DEPTH - 1), "front pointer out of range")
  `BDQS_ASSERT_IMP(a_search_idx, searching, idx_q <= cnt_q, "search index past count")
  `BDQS_ASSERT_IMP(a_busy_search, searching, !in_ready_o && !out_valid_q, "beat during search")
  `BDQS_ASSERT_IMP(a_found_ok, rsp_q.found, rsp_q.status == STATUS_OK, "found with bad status")
  `BDQS_ASSERT_NXT(a_search_hold, searching, $stable(cnt_q) && $stable(front_q), "deque moved")

endmodule
`default_nettype wire

/* sv/bdqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdqs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
